@@ rtl/core/hpl_pkg.sv @@
`default_nettype none
package hpl_pkg;

  // Field widths
  localparam int LAT_W    = 31;
  localparam int LON_W    = 32;
  localparam int RADIUS_W = 23;
  localparam int LEN_W    = 48;
  localparam int SEG_W    = 34;
  localparam int COORD_W  = 34;
  localparam int RAD_W    = 31;

  // Fixed-point constants
  localparam logic [63:0] PI_Q61          = 64'h6487ED5110B4611A;
  localparam logic [63:0] QUARTER_PI_Q62  = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q32        = 64'h9B74EDA8;
  localparam logic [63:0] HALF_TURN_UNITS = 64'd1800000000;
  // pi / (180 * 1e7) in Q60
  localparam logic [63:0] RAD_Q60         = PI_Q61 / (64'd2 * HALF_TURN_UNITS);

  localparam logic [LEN_W-1:0]    SUM_MAX      = '1;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

  typedef struct packed {
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic                    last_point;
  } hpl_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] path_length;
    logic             saturated;
  } hpl_out_t;

  typedef enum logic {
    MODE_ROTATE = 1'b0,
    MODE_VECTOR = 1'b1
  } cordic_mode_t;

  // Rounding shift applied after a multiply
  typedef enum logic [1:0] {
    SHIFT_FRAC       = 2'd0,
    SHIFT_HALF_ANGLE = 2'd1,
    SHIFT_ANGLE      = 2'd2,
    SHIFT_DIST       = 2'd3
  } shift_sel_t;

  typedef struct packed {
    logic       start;
    logic       negate;
    shift_sel_t shift;
  } mul_cmd_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_cmd_t;

  // Restoring unsigned division (elaboration only)
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q62, truncated-term series (elaboration only)
  function automatic logic [63:0] atan_q62(input int unsigned i);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    int unsigned e;
    int unsigned k;
    if (i == 0) return QUARTER_PI_Q62;
    pos = '0;
    neg = '0;
    for (k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) neg = neg + t;
        else pos = pos + t;
      end
    end
    return pos - neg;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/hpl_mul.sv @@
`default_nettype none
// Registered unsigned multiply, then round half up, shift and apply sign
module hpl_mul #(
  parameter int MW = 34,
  parameter int F  = 30
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hpl_pkg::mul_cmd_t cmd,
  input  wire logic [MW-1:0]     a,
  input  wire logic [MW-1:0]     b,
  output logic                   done,
  output logic [2*MW-1:0]        result
);

  localparam int PW     = 2 * MW;
  localparam int S_FRAC = F;
  localparam int S_HALF = 61 - F;
  localparam int S_ANG  = 60 - F;
  localparam int S_DIST = F - 9;
  localparam logic [PW:0] R_FRAC = (PW+1)'(1) << (S_FRAC - 1);
  localparam logic [PW:0] R_HALF = (PW+1)'(1) << (S_HALF - 1);
  localparam logic [PW:0] R_ANG  = (PW+1)'(1) << (S_ANG - 1);
  localparam logic [PW:0] R_DIST = (PW+1)'(1) << (S_DIST - 1);

  logic [PW-1:0]       prod;
  logic                negate_q;
  hpl_pkg::shift_sel_t shift_q;
  logic                stage1;
  logic [PW:0]         prod_ext;
  logic [PW:0]         rounded;
  logic [PW-1:0]       shifted;

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= cmd.start;
      done   <= stage1;
    end
  end

  // Rounding select
  always_comb begin
    prod_ext = {1'b0, prod};
    unique case (shift_q)
      hpl_pkg::SHIFT_FRAC:       rounded = (prod_ext + R_FRAC) >> S_FRAC;
      hpl_pkg::SHIFT_HALF_ANGLE: rounded = (prod_ext + R_HALF) >> S_HALF;
      hpl_pkg::SHIFT_ANGLE:      rounded = (prod_ext + R_ANG) >> S_ANG;
      hpl_pkg::SHIFT_DIST:       rounded = (prod_ext + R_DIST) >> S_DIST;
      default:                   rounded = prod_ext;
    endcase
    shifted = rounded[PW-1:0];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      prod     <= PW'(a) * PW'(b);
      negate_q <= cmd.negate;
      shift_q  <= cmd.shift;
    end
    if (stage1) begin
      result <= negate_q ? -shifted : shifted;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/hpl_cordic.sv @@
`default_nettype none
// Shared CORDIC engine, one micro-rotation per cycle, rotation or vectoring
module hpl_cordic #(
  parameter int N = 32,
  parameter int F = 30,
  parameter int W = 34
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hpl_pkg::cordic_cmd_t cmd,
  input  wire logic signed [W-1:0]  x0,
  input  wire logic signed [W-1:0]  y0,
  input  wire logic signed [W-1:0]  z0,
  output logic                      done,
  output logic signed [W-1:0]       sine,
  output logic signed [W-1:0]       cosine,
  output logic signed [W-1:0]       angle
);

  localparam int CW = $clog2(N);
  localparam logic [63:0] PI_F   = (hpl_pkg::PI_Q61 + (64'd1 << (60 - F))) >> (61 - F);
  localparam logic [63:0] HALF_F = (hpl_pkg::PI_Q61 + (64'd1 << (61 - F))) >> (62 - F);
  localparam logic [63:0] GAIN_F = (F >= 32) ? (hpl_pkg::GAIN_Q32 << (F - 32))
                                 : ((hpl_pkg::GAIN_Q32 + (64'd1 << (31 - F))) >> (32 - F));
  localparam logic signed [W-1:0] PI_W   = W'(PI_F);
  localparam logic signed [W-1:0] HALF_W = W'(HALF_F);
  localparam logic signed [W-1:0] GAIN_W = W'(GAIN_F);

  logic signed [W-1:0] atan_tab [N];

  // Arctangent steps rounded to Q(F)
  for (genvar g = 0; g < N; g++) begin : g_atan
    localparam logic [63:0] STEP_Q62 = hpl_pkg::atan_q62(g);
    localparam logic [63:0] STEP_F   = (STEP_Q62 + (64'd1 << (61 - F))) >> (62 - F);
    assign atan_tab[g] = W'(STEP_F);
  end

  logic signed [W-1:0]   x;
  logic signed [W-1:0]   y;
  logic signed [W-1:0]   z;
  logic                  flip;
  hpl_pkg::cordic_mode_t mode;
  logic                  busy;
  logic [CW-1:0]         iter;
  logic signed [W-1:0]   dx;
  logic signed [W-1:0]   dy;
  logic signed [W-1:0]   step_angle;
  logic                  go_neg;

  always_comb begin
    dx         = y >>> iter;
    dy         = x >>> iter;
    step_angle = atan_tab[iter];
    go_neg     = (mode == hpl_pkg::MODE_ROTATE) ? ~z[W-1] : y[W-1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        if (iter == CW'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  // Datapath: load (with quadrant fold in rotation mode), then iterate
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode <= cmd.mode;
      if (cmd.mode == hpl_pkg::MODE_ROTATE) begin
        x <= GAIN_W;
        y <= '0;
        if (z0 > HALF_W) begin
          z    <= z0 - PI_W;
          flip <= 1'b1;
        end else if (z0 < -HALF_W) begin
          z    <= z0 + PI_W;
          flip <= 1'b1;
        end else begin
          z    <= z0;
          flip <= 1'b0;
        end
      end else begin
        x    <= x0;
        y    <= y0;
        z    <= '0;
        flip <= 1'b0;
      end
    end else if (busy) begin
      x <= go_neg ? x - dx : x + dx;
      y <= go_neg ? y + dy : y - dy;
      z <= go_neg ? z - step_angle : z + step_angle;
    end
  end

  assign sine   = flip ? -y : y;
  assign cosine = flip ? -x : x;
  assign angle  = z;

endmodule
`default_nettype wire

@@ rtl/core/hpl_sqrt.sv @@
`default_nettype none
// Restoring square root of value * 2^F, one result bit per cycle
module hpl_sqrt #(
  parameter int F = 30
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [F:0] value,
  output logic            done,
  output logic [F:0]      root
);

  localparam int RDW  = 2 * F + 2;
  localparam int REMW = F + 4;
  localparam int CW   = $clog2(F + 1);

  logic [RDW-1:0]  rad;
  logic [REMW-1:0] rem;
  logic [REMW-1:0] rem_shift;
  logic [REMW-1:0] trial;
  logic            fits;
  logic            busy;
  logic [CW-1:0]   count;

  always_comb begin
    rem_shift = {rem[REMW-3:0], rad[RDW-1 -: 2]};
    trial     = REMW'({root, 2'b01});
    fits      = rem_shift >= trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == CW'(F)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {1'b0, value, {F{1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? rem_shift - trial : rem_shift;
      root <= {root[F-1:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/haversine_path_length_core.sv @@
`default_nettype none
// Great-circle path length accumulator (haversine).
// Points of a path arrive as beats on in_valid/in_ready: latitude and
// longitude in 1e-7 degree, last_point marking the end of the path. Each
// point after the first adds the distance from the previous point. The
// beat carrying last_point produces one out beat with the total length in
// 1/256 m (clamped at full scale, with a saturated flag) and clears the
// path state; a single-point path gives 0.
// cfg_valid/cfg_ready write earth_radius_m (always ready); write it only
// while no point is in flight.
// A later point of a path makes five passes through the shared CORDIC unit,
// two root extractions and nine passes through the multiplier; the first
// point of a path makes none. in_ready is high only between points. A
// result waits in the output register until out_ready; a final point
// arriving meanwhile holds until the register is free.
// Reset (rst, synchronous) clears the path state, drops out_valid and loads
// the radius with 6371000 m.
module haversine_path_length_core #(
  parameter int CORDIC_ITERATIONS   = 32,
  parameter int ANGLE_FRACTION_BITS = 30
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire hpl_pkg::hpl_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output hpl_pkg::hpl_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hpl_pkg::RADIUS_W-1:0]     cfg_data
);

  localparam int F  = ANGLE_FRACTION_BITS;
  localparam int N  = CORDIC_ITERATIONS;
  localparam int W  = F + 4;
  localparam int MW = (W > 32) ? W : 32;
  localparam int PW = 2 * MW;
  localparam int CDW = hpl_pkg::COORD_W;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_ANGLE   = 8'b0000_0010,
    ST_ROTATE  = 8'b0000_0100,
    ST_PRODUCT = 8'b0000_1000,
    ST_ROOT    = 8'b0001_0000,
    ST_VECTOR  = 8'b0010_0000,
    ST_DIST    = 8'b0100_0000,
    ST_ACCUM   = 8'b1000_0000
  } state_t;

  state_t                                 state;
  logic [1:0]                             step;
  logic                                   pending;
  logic                                   have_prev;
  logic signed [hpl_pkg::LAT_W-1:0]       prev_lat;
  logic signed [hpl_pkg::LON_W-1:0]       prev_lon;
  logic [hpl_pkg::LEN_W-1:0]              sum;
  logic                                   ovf;
  logic [hpl_pkg::RADIUS_W-1:0]           radius;

  hpl_pkg::hpl_in_t                       cur;
  logic                                   with_segment;
  logic signed [W-1:0]                    ang_dlat;
  logic signed [W-1:0]                    ang_dlon;
  logic signed [W-1:0]                    ang_lat1;
  logic signed [W-1:0]                    ang_lat2;
  logic signed [W-1:0]                    s1;
  logic signed [W-1:0]                    s2;
  logic signed [W-1:0]                    ca;
  logic signed [W-1:0]                    cb;
  logic signed [W-1:0]                    p1;
  logic signed [W-1:0]                    p2;
  logic signed [W-1:0]                    p3;
  logic [F:0]                             a_val;
  logic [F:0]                             rx;
  logic [F:0]                             ry;
  logic [W-1:0]                           zang;
  logic [hpl_pkg::SEG_W-1:0]              seg;

  // Shared unit hookup
  hpl_pkg::mul_cmd_t    mul_cmd;
  logic [MW-1:0]        mul_a;
  logic [MW-1:0]        mul_b;
  logic                 mul_done;
  logic [PW-1:0]        mul_res;
  hpl_pkg::cordic_cmd_t cordic_cmd;
  logic signed [W-1:0]  cordic_x0;
  logic signed [W-1:0]  cordic_y0;
  logic signed [W-1:0]  cordic_z0;
  logic                 cordic_done;
  logic signed [W-1:0]  cordic_sin;
  logic signed [W-1:0]  cordic_cos;
  logic signed [W-1:0]  cordic_angle;
  logic                 sqrt_start;
  logic [F:0]           sqrt_value;
  logic                 sqrt_done;
  logic [F:0]           sqrt_root;

  logic signed [CDW-1:0]      coord;
  logic [CDW-1:0]             coord_mag;
  logic signed [W-1:0]        op_l;
  logic signed [W-1:0]        op_r;
  logic [W-1:0]               mag_l;
  logic [W-1:0]               mag_r;
  logic signed [W-1:0]        mul_w;
  logic signed [W:0]          a_sum;
  logic [F:0]                 a_clamped;
  logic [hpl_pkg::LEN_W:0]    sum_add;
  logic [hpl_pkg::LEN_W-1:0]  sum_new;
  logic                       ovf_new;
  logic                       emit_ok;
  logic                       emit;

  hpl_mul #(.MW(MW), .F(F)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mul_cmd),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  hpl_cordic #(.N(N), .F(F), .W(W)) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cordic_cmd),
    .x0     (cordic_x0),
    .y0     (cordic_y0),
    .z0     (cordic_z0),
    .done   (cordic_done),
    .sine   (cordic_sin),
    .cosine (cordic_cos),
    .angle  (cordic_angle)
  );

  hpl_sqrt #(.F(F)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sqrt_value),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Operand selection for degree-to-radian conversion
  always_comb begin
    unique case (step)
      2'd0:    coord = CDW'($signed(cur.latitude)) - CDW'(prev_lat);
      2'd1:    coord = CDW'($signed(cur.longitude)) - CDW'(prev_lon);
      2'd2:    coord = CDW'(prev_lat);
      default: coord = CDW'($signed(cur.latitude));
    endcase
    coord_mag = coord[CDW-1] ? -coord : coord;
  end

  // Operand selection for the products forming a
  always_comb begin
    unique case (step)
      2'd0:    begin op_l = s1; op_r = s1; end
      2'd1:    begin op_l = ca; op_r = cb; end
      2'd2:    begin op_l = s2; op_r = s2; end
      default: begin op_l = p2; op_r = p3; end
    endcase
    mag_l = op_l[W-1] ? -op_l : op_l;
    mag_r = op_r[W-1] ? -op_r : op_r;
    mul_w = mul_res[W-1:0];
    a_sum = (W+1)'(p1) + (W+1)'(mul_w);
    if (a_sum[W]) a_clamped = '0;
    else if (a_sum > $signed({{(W-F){1'b0}}, ONE})) a_clamped = ONE;
    else a_clamped = a_sum[F:0];
  end

  // Unit commands
  always_comb begin
    mul_cmd        = '0;
    mul_cmd.shift  = hpl_pkg::SHIFT_FRAC;
    mul_a          = MW'(mag_l);
    mul_b          = MW'(mag_r);
    cordic_cmd     = '0;
    cordic_cmd.mode = hpl_pkg::MODE_ROTATE;
    cordic_x0      = $signed(W'(rx));
    cordic_y0      = $signed(W'(ry));
    sqrt_start     = 1'b0;
    sqrt_value     = step[0] ? a_val : ONE - a_val;
    unique case (step)
      2'd0:    cordic_z0 = ang_dlat;
      2'd1:    cordic_z0 = ang_dlon;
      2'd2:    cordic_z0 = ang_lat1;
      default: cordic_z0 = ang_lat2;
    endcase
    unique case (state)
      ST_ANGLE: begin
        mul_cmd.start  = ~pending;
        mul_cmd.negate = coord[CDW-1];
        mul_cmd.shift  = step[1] ? hpl_pkg::SHIFT_ANGLE : hpl_pkg::SHIFT_HALF_ANGLE;
        mul_a          = MW'(coord_mag[31:0]);
        mul_b          = MW'(hpl_pkg::RAD_Q60[hpl_pkg::RAD_W-1:0]);
      end
      ST_ROTATE: cordic_cmd.start = ~pending;
      ST_PRODUCT: begin
        mul_cmd.start  = ~pending;
        mul_cmd.negate = op_l[W-1] ^ op_r[W-1];
      end
      ST_ROOT: sqrt_start = ~pending;
      ST_VECTOR: begin
        cordic_cmd.start = ~pending;
        cordic_cmd.mode  = hpl_pkg::MODE_VECTOR;
      end
      ST_DIST: begin
        mul_cmd.start = ~pending;
        mul_cmd.shift = hpl_pkg::SHIFT_DIST;
        mul_a         = MW'(zang);
        mul_b         = MW'(radius);
      end
      default: ;
    endcase
  end

  // Saturating accumulate
  always_comb begin
    sum_add = {1'b0, sum} + (with_segment ? (hpl_pkg::LEN_W+1)'(seg) : '0);
    sum_new = sum_add[hpl_pkg::LEN_W] ? hpl_pkg::SUM_MAX : sum_add[hpl_pkg::LEN_W-1:0];
    ovf_new = ovf | sum_add[hpl_pkg::LEN_W];
    emit_ok = ~out_valid | out_ready;
    emit    = (state == ST_ACCUM) && cur.last_point && emit_ok;
  end

  // Sequencer and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      pending   <= 1'b0;
      have_prev <= 1'b0;
      prev_lat  <= '0;
      prev_lon  <= '0;
      sum       <= '0;
      ovf       <= 1'b0;
      radius    <= hpl_pkg::RADIUS_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) radius <= cfg_data;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            step    <= '0;
            pending <= 1'b0;
            state   <= have_prev ? ST_ANGLE : ST_ACCUM;
          end
        end
        ST_ANGLE, ST_ROTATE, ST_PRODUCT: begin
          if (!pending) pending <= 1'b1;
          if (mul_done || cordic_done) begin
            pending <= 1'b0;
            step    <= step + 1'b1;
            if (step == 2'd3) begin
              priority case (1'b1)
                state == ST_ANGLE:  state <= ST_ROTATE;
                state == ST_ROTATE: state <= ST_PRODUCT;
                default:            state <= ST_ROOT;
              endcase
            end
          end
        end
        ST_ROOT: begin
          if (!pending) pending <= 1'b1;
          if (sqrt_done) begin
            pending <= 1'b0;
            step    <= step + 1'b1;
            if (step[0]) state <= ST_VECTOR;
          end
        end
        ST_VECTOR: begin
          if (!pending) pending <= 1'b1;
          if (cordic_done) begin
            pending <= 1'b0;
            state   <= ST_DIST;
          end
        end
        ST_DIST: begin
          if (!pending) pending <= 1'b1;
          if (mul_done) begin
            pending <= 1'b0;
            state   <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (!cur.last_point) begin
            sum       <= sum_new;
            ovf       <= ovf_new;
            prev_lat  <= cur.latitude;
            prev_lon  <= cur.longitude;
            have_prev <= 1'b1;
            state     <= ST_IDLE;
          end else if (emit_ok) begin
            sum       <= '0;
            ovf       <= 1'b0;
            prev_lat  <= '0;
            prev_lon  <= '0;
            have_prev <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cur          <= in_data;
      with_segment <= have_prev;
    end
    if (state == ST_ANGLE && mul_done) begin
      unique case (step)
        2'd0:    ang_dlat <= mul_w;
        2'd1:    ang_dlon <= mul_w;
        2'd2:    ang_lat1 <= mul_w;
        default: ang_lat2 <= mul_w;
      endcase
    end
    if (state == ST_ROTATE && cordic_done) begin
      unique case (step)
        2'd0:    s1 <= cordic_sin;
        2'd1:    s2 <= cordic_sin;
        2'd2:    ca <= cordic_cos;
        default: cb <= cordic_cos;
      endcase
    end
    if (state == ST_PRODUCT && mul_done) begin
      unique case (step)
        2'd0:    p1    <= mul_w;
        2'd1:    p2    <= mul_w;
        2'd2:    p3    <= mul_w;
        default: a_val <= a_clamped;
      endcase
    end
    if (state == ST_ROOT && sqrt_done) begin
      if (step[0]) ry <= sqrt_root;
      else rx <= sqrt_root;
    end
    if (state == ST_VECTOR && cordic_done) begin
      zang <= cordic_angle[W-1] ? '0 : cordic_angle;
    end
    if (state == ST_DIST && mul_done) begin
      seg <= mul_res[hpl_pkg::SEG_W-1:0];
    end
    if (emit) begin
      out_data.path_length <= sum_new;
      out_data.saturated   <= ovf_new;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready again straight after taking a point");

  a_overflow_means_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (sum == hpl_pkg::SUM_MAX))
    else $error("overflow flag set but sum not at full scale");

  a_one_unit_started: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_cmd.start, cordic_cmd.start, sqrt_start}))
    else $error("more than one arithmetic unit started at once");

  a_root_operand_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> (a_val <= ONE))
    else $error("haversine term above one at root extraction");

endmodule
`default_nettype wire

@@ verif/haversine_path_length_core_tb.sv @@
`timescale 1ns / 1ps
module haversine_path_length_core_tb;

  localparam int ITERS = 32;
  localparam int FRAC  = 30;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  hpl_pkg::hpl_in_t in_data;
  logic out_valid;
  logic out_ready;
  hpl_pkg::hpl_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [hpl_pkg::RADIUS_W-1:0] cfg_data;

  haversine_path_length_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // path state of the predictor
  logic [hpl_pkg::RADIUS_W-1:0] radius_m;
  longint prev_lat, prev_lon;
  bit has_prev;
  logic [63:0] sum_len;
  bit sum_clamped;
  longint atan_q[ITERS];

  hpl_pkg::hpl_out_t lengths_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // rounding right shift, half up
  function automatic logic [63:0] round_shr(logic [63:0] v, int s);
    if (s == 0) return v;
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  // full product, rounded half up, then shifted
  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (s - 1))) >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint r;
    r = longint'(mul_round(magn(a), magn(b), FRAC));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint deg_to_rad(longint d, int s);
    longint r;
    r = longint'(round_shr(magn(d) * hpl_pkg::RAD_Q60, s));
    return d < 0 ? -r : r;
  endfunction

  // rotation CORDIC, quadrant folded into +-pi/2
  task automatic sin_cos(input longint ang, output longint sn, output longint cs);
    longint pi_q, half_q, x, y, z, dx, dy;
    bit flip;
    pi_q = longint'(round_shr(hpl_pkg::PI_Q61, 61 - FRAC));
    half_q = longint'(round_shr(hpl_pkg::PI_Q61, 62 - FRAC));
    x = longint'(round_shr(hpl_pkg::GAIN_Q32, 32 - FRAC));
    y = 0;
    z = ang;
    flip = 1'b0;
    if (z > half_q) begin
      z -= pi_q;
      flip = 1'b1;
    end else if (z < -half_q) begin
      z += pi_q;
      flip = 1'b1;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q[i];
      end else begin
        x += dx; y -= dy; z += atan_q[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // floor(sqrt(v * 2^FRAC)), restoring
  function automatic longint root_frac(logic [63:0] v);
    logic [63:0] val, rem, root, trial;
    val = v << FRAC;
    rem = 0;
    root = 0;
    for (int k = FRAC; k >= 0; k--) begin
      rem = (rem << 2) | ((val >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  task automatic hop_length(input longint la1, input longint lo1, input longint la2,
                            input longint lo2, output logic [63:0] len);
    longint s1, c1, s2, c2, sa, ca, sb, cb, a, x, y, z, dx, dy;
    longint one;
    one = longint'(1) << FRAC;
    sin_cos(deg_to_rad(la2 - la1, 61 - FRAC), s1, c1);
    sin_cos(deg_to_rad(lo2 - lo1, 61 - FRAC), s2, c2);
    sin_cos(deg_to_rad(la1, 60 - FRAC), sa, ca);
    sin_cos(deg_to_rad(la2, 60 - FRAC), sb, cb);
    a = fx_mul(s1, s1) + fx_mul(fx_mul(ca, cb), fx_mul(s2, s2));
    if (a < 0) a = 0;
    if (a > one) a = one;
    x = root_frac(64'(one - a));
    y = root_frac(64'(a));
    z = 0;
    // vectoring CORDIC gives atan2(sqrt(a), sqrt(1-a))
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q[i];
      end else begin
        x -= dx; y += dy; z -= atan_q[i];
      end
    end
    if (z < 0) z = 0;
    len = mul_round(64'(z), 64'(radius_m), FRAC - 9);
  endtask

  // advance the path state by one point; returns 1 when a total is due
  task automatic path_step(input hpl_pkg::hpl_in_t p, output bit due,
                           output hpl_pkg::hpl_out_t total);
    longint lat, lon;
    logic [63:0] hop;
    lat = longint'($signed(p.latitude));
    lon = longint'($signed(p.longitude));
    if (has_prev) begin
      hop_length(prev_lat, prev_lon, lat, lon, hop);
      sum_len += hop;
      if (sum_len > LEN_MAX) begin
        sum_len = LEN_MAX;
        sum_clamped = 1'b1;
      end
    end
    prev_lat = lat;
    prev_lon = lon;
    has_prev = 1'b1;
    due = p.last_point;
    total.path_length = sum_len[hpl_pkg::LEN_W-1:0];
    total.saturated = sum_clamped;
    if (p.last_point) begin
      prev_lat = 0;
      prev_lon = 0;
      has_prev = 1'b0;
      sum_len = 0;
      sum_clamped = 1'b0;
    end
  endtask

  // series for atan(2^-i) in Q62, rounded to the working fraction
  initial begin
    logic [63:0] pos, neg, q;
    longint e;
    for (int i = 0; i < ITERS; i++) begin
      q = hpl_pkg::QUARTER_PI_Q62;
      if (i > 0) begin
        pos = 0;
        neg = 0;
        for (int k = 0; k < 64; k++) begin
          e = longint'(i) * (2 * k + 1);
          if (e <= 62) begin
            if (k % 2) neg += (64'd1 << (62 - e)) / (2 * k + 1);
            else pos += (64'd1 << (62 - e)) / (2 * k + 1);
          end
        end
        q = pos - neg;
      end
      atan_q[i] = longint'(round_shr(q, 62 - FRAC));
    end
  end

  // one point beat; the total is worked out when the beat is taken
  task automatic send_point(input hpl_pkg::hpl_in_t p, input bit fixed,
                            input hpl_pkg::hpl_out_t fixed_total);
    bit due;
    hpl_pkg::hpl_out_t total;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    path_step(p, due, total);
    if (due) lengths_due.push_back(fixed ? fixed_total : total);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (lengths_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [hpl_pkg::RADIUS_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_m = r;
  endtask

  longint walk_lat, walk_lon;

  // mostly plausible points, some near the last one, some raw bit patterns
  function automatic hpl_pkg::hpl_in_t pick_point(bit last);
    hpl_pkg::hpl_in_t p;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      walk_lat += longint'($urandom_range(0, 2000000)) - 1000000;
      walk_lon += longint'($urandom_range(0, 2000000)) - 1000000;
    end else if (r < 85) begin
      walk_lat = longint'($urandom_range(0, 1800000000)) - 900000000;
      walk_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
    end else begin
      walk_lat = longint'($signed(31'($urandom())));
      walk_lon = longint'($signed(32'($urandom())));
    end
    p.latitude = walk_lat[hpl_pkg::LAT_W-1:0];
    p.longitude = walk_lon[hpl_pkg::LON_W-1:0];
    p.last_point = last;
    return p;
  endfunction

  task automatic random_paths(input int n_points);
    int left, run;
    hpl_pkg::hpl_out_t none;
    none = '0;
    left = n_points;
    while (left > 0) begin
      run = $urandom_range(1, 8);
      if (run > left) run = left;
      for (int j = 0; j < run; j++) send_point(pick_point(j == run - 1), 1'b0, none);
      left -= run;
    end
  endtask

  // directed rows: point, and a typed total where one is obvious
  typedef struct {
    int lat;
    int lon;
    bit last;
    bit fixed;
    longint total;
  } point_row_t;

  point_row_t directed_rows[] = '{
    '{0, 0, 1, 1, 0},                          // lone point gives zero
    '{123456789, -98765432, 1, 1, 0},
    '{0, 0, 0, 0, 0}, '{0, 0, 1, 0, 0},        // zero-length hop
    '{900000000, 1800000000, 0, 0, 0},
    '{-900000000, -1800000000, 1, 0, 0},
    '{0, -1800000000, 0, 0, 0}, '{0, 1800000000, 1, 0, 0},
    '{-1073741824, -2147483648, 0, 0, 0},      // beyond the legal range
    '{1073741823, 2147483647, 1, 0, 0},
    '{515000000, -1270000, 0, 0, 0},           // return to the first point
    '{488566000, 23522000, 0, 0, 0},
    '{515000000, -1270000, 0, 0, 0}, '{515000000, -1270000, 1, 0, 0},
    '{450000000, 0, 0, 0, 0}, '{450000000, 1, 0, 0, 0}, '{450000001, 1, 1, 0, 0},
    '{-900000000, 0, 0, 0, 0}, '{900000000, 0, 1, 0, 0},
    '{0, 0, 0, 0, 0}, '{0, 1800000000, 1, 0, 0}  // antipodal on the equator
  };

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // compare each output beat with the oldest pending total
  always @(posedge clk) begin
    hpl_pkg::hpl_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (lengths_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: length %0d sat %0b",
                                   out_data.path_length, out_data.saturated);
      end else begin
        want = lengths_due.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected length %0d sat %0b, got length %0d sat %0b",
                     want.path_length, want.saturated,
                     out_data.path_length, out_data.saturated);
        end
      end
    end
  end

  initial begin
    hpl_pkg::hpl_in_t p;
    hpl_pkg::hpl_out_t t;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    radius_m = hpl_pkg::RADIUS_RESET;
    prev_lat = 0;
    prev_lon = 0;
    has_prev = 1'b0;
    sum_len = 0;
    sum_clamped = 1'b0;
    walk_lat = 0;
    walk_lon = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed points at the reset radius
    send_idle_pct = 31;
    recv_idle_pct = 68;
    foreach (directed_rows[i]) begin
      p.latitude = directed_rows[i].lat[hpl_pkg::LAT_W-1:0];
      p.longitude = directed_rows[i].lon;
      p.last_point = directed_rows[i].last;
      t.path_length = directed_rows[i].total[hpl_pkg::LEN_W-1:0];
      t.saturated = 1'b0;
      send_point(p, directed_rows[i].fixed, t);
    end
    drain();

    // zero radius: every path measures zero
    write_radius('0);
    t = '0;
    for (int j = 0; j < 4; j++) send_point(pick_point(j == 3), 1'b1, t);
    drain();

    write_radius(23'h7FFFFF);
    random_paths(260);
    drain();

    send_idle_pct = 68;
    recv_idle_pct = 31;
    write_radius(23'd1);
    random_paths(260);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_radius(hpl_pkg::RADIUS_W'($urandom_range(1, 8388607)));
    random_paths(230);
    drain();

    write_radius(hpl_pkg::RADIUS_RESET);
    random_paths(20);
    drain();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule
